/* sv/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, constants and the CRC-8 byte update for the frame encoder.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_CRC_POLY    = 2'd1;
    localparam logic [1:0] REG_CRC_START   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;
    localparam logic [7:0]  CRC_POLY_RESET    = 8'h31;
    localparam logic [7:0]  CRC_START_RESET   = 8'h00;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // byte positions within the output sequence of one command
    localparam logic [2:0] POS_SYNC1  = 3'd0;
    localparam logic [2:0] POS_SYNC2  = 3'd1;
    localparam logic [2:0] POS_LEN_LO = 3'd2;
    localparam logic [2:0] POS_LEN_HI = 3'd3;
    localparam logic [2:0] POS_DATA   = 3'd4;
    localparam logic [2:0] POS_CRC    = 3'd5;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // work handed from the front to the back
    typedef struct packed {
        logic        rej;    // reject result only
        logic        hdr;    // emit sync and length first
        logic        close;  // emit crc byte after the payload byte
        logic [15:0] len;
        logic [7:0]  data;
        logic [7:0]  crc;
    } cmd_t;

    // msb-first crc-8 over one byte, eight bit steps unrolled
    function automatic logic [7:0] crc8_byte(
        input logic [7:0] crc_in,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* sv/crc8_binary_frame_encoder_unit.sv */
// ----------------------------------------------------------------------------
// crc8_binary_frame_encoder_unit
// Wraps payload bytes into frames: 0xAA 0x55, little-endian length, payload,
// CRC-8. Bad starts give one reject result.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle as long as the command queue
// (QUEUE_DEPTH entries) has room; classification and the full eight-bit CRC
// update happen combinationally as the item is accepted. The output side
// delivers one byte per cycle while result_stall is low, so an item that
// opens a frame yields five bytes (six when it also closes it), an ordinary
// payload byte one byte and a payload byte that closes a frame two. Sustained
// throughput is therefore set by the output port at one byte per transfer;
// the queue absorbs header bursts. Configuration is taken whenever
// cfg_write_en is high and should only change while no item is in flight.
// ----------------------------------------------------------------------------
module crc8_binary_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [cfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [7:0]                      payload_byte,
    input  logic                            start_of_frame,
    input  logic [15:0]                     frame_length,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [7:0]                      out_byte,
    output logic                            end_of_frame,
    output logic                            last_of_run,
    output logic                            rejected
);
    import cfe_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    cfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .payload_byte   (payload_byte),
        .start_of_frame (start_of_frame),
        .frame_length   (frame_length),
        .push           (push),
        .push_cmd       (push_cmd),
        .queue_full     (queue_full)
    );

    cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run),
        .rejected     (rejected)
    );

endmodule

/* sv/cfe_front.sv */
// ----------------------------------------------------------------------------
// cfe_front
// Accepts input items, tracks the open frame and running crc, and turns each
// item, except a byte outside a frame, into a command for the output sequencer.
// ----------------------------------------------------------------------------
module cfe_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [cfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [7:0]                      payload_byte,
    input  logic                            start_of_frame,
    input  logic [15:0]                     frame_length,
    output logic                            push,
    output cfe_pkg::cmd_t                   push_cmd,
    input  logic                            queue_full
);
    import cfe_pkg::*;

    logic [15:0] max_payload_reg;
    logic [7:0]  crc_poly_reg;
    logic [7:0]  crc_start_reg;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  crc_reg, crc_next;

    logic        accept;
    logic        bad_len;
    logic [7:0]  crc_base;
    logic [7:0]  crc_new;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    assign bad_len  = (frame_length == 16'd0) || (frame_length > max_payload_reg);
    assign crc_base = start_of_frame ? crc_start_reg : crc_reg;
    assign crc_new  = crc8_byte(crc_base, payload_byte, crc_poly_reg);

    always_comb
    begin
        remain_next = remain_reg;
        crc_next    = crc_reg;
        push        = 1'b0;
        push_cmd    = '0;
        push_cmd.data = payload_byte;
        push_cmd.len  = frame_length;
        push_cmd.crc  = crc_new;
        if (accept)
        begin
            priority if (start_of_frame && bad_len)
            begin
                push         = 1'b1;
                push_cmd.rej = 1'b1;
                remain_next  = 16'd0;
            end
            else if (start_of_frame)
            begin
                push           = 1'b1;
                push_cmd.hdr   = 1'b1;
                push_cmd.close = (frame_length == 16'd1);
                remain_next    = frame_length - 16'd1;
                crc_next       = crc_new;
            end
            else if (remain_reg != 16'd0)
            begin
                push           = 1'b1;
                push_cmd.close = (remain_reg == 16'd1);
                remain_next    = remain_reg - 16'd1;
                crc_next       = crc_new;
            end
            // byte with no frame open is dropped
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            crc_poly_reg    <= CRC_POLY_RESET;
            crc_start_reg   <= CRC_START_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                REG_CRC_POLY:    crc_poly_reg    <= cfg_data[7:0];
                REG_CRC_START:   crc_start_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 16'd0;
            crc_reg    <= 8'd0;
        end
        else
        begin
            remain_reg <= remain_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

/* sv/cfe_queue.sv */
// ----------------------------------------------------------------------------
// cfe_queue
// Small command queue between the front and the output sequencer.
// ----------------------------------------------------------------------------
module cfe_queue #(
    parameter int DEPTH = cfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output cfe_pkg::cmd_t head_cmd
);
    import cfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/cfe_back.sv */
// ----------------------------------------------------------------------------
// cfe_back
// Output sequencer: walks each queued command through its bytes and holds
// one result in an output register.
// ----------------------------------------------------------------------------
module cfe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  cfe_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output logic [7:0]    out_byte,
    output logic          end_of_frame,
    output logic          last_of_run,
    output logic          rejected
);
    import cfe_pkg::*;

    logic [2:0] step_reg, step_next;
    logic [2:0] pos;
    logic       load;
    logic       last;
    logic [7:0] byte_val;
    logic       eof_val;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       eof_reg, last_reg, rej_reg;

    // commands without a header start at the payload byte
    assign pos  = head_cmd.hdr ? step_reg : step_reg + POS_DATA;
    assign load = head_valid && (!valid_reg || !result_stall);
    assign last = head_cmd.rej || pos == POS_CRC || (pos == POS_DATA && !head_cmd.close);
    assign pop  = load && last;

    always_comb
    begin
        eof_val = 1'b0;
        unique case (pos)
            POS_SYNC1:  byte_val = SYNC_FIRST;
            POS_SYNC2:  byte_val = SYNC_SECOND;
            POS_LEN_LO: byte_val = head_cmd.len[7:0];
            POS_LEN_HI: byte_val = head_cmd.len[15:8];
            POS_DATA:   byte_val = head_cmd.data;
            POS_CRC:
            begin
                byte_val = head_cmd.crc;
                eof_val  = 1'b1;
            end
            default:    byte_val = 8'd0;
        endcase
        if (head_cmd.rej)
        begin
            byte_val = 8'd0;
            eof_val  = 1'b0;
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = last ? 3'd0 : step_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_val;
            eof_reg  <= eof_val;
            last_reg <= last;
            rej_reg  <= head_cmd.rej;
        end
    end

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign end_of_frame = eof_reg;
    assign last_of_run  = last_reg;
    assign rejected     = rej_reg;

endmodule

/* sim/frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches the item, result and register ports of the frame encoder, builds
// the framed byte stream each accepted item should produce and compares every
// result transfer against it in order.
// ----------------------------------------------------------------------------
module frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [cfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  logic [7:0]                      payload_byte,
    input  logic                            start_of_frame,
    input  logic [15:0]                     frame_length,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic [7:0]                      out_byte,
    input  logic                            end_of_frame,
    input  logic                            last_of_run,
    input  logic                            rejected,
    output int                              mismatch_count,
    output int                              bytes_pending
);
    import cfe_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       last;
        logic       rej;
    } framed_byte_t;

    logic [15:0]  max_len_cfg = MAX_PAYLOAD_RESET;
    logic [7:0]   poly_cfg    = CRC_POLY_RESET;
    logic [7:0]   seed_cfg    = CRC_START_RESET;
    logic [15:0]  bytes_left  = '0;
    logic [7:0]   crc_acc     = '0;
    framed_byte_t framed_q[$];

    function automatic framed_byte_t framed(input logic [7:0] data, input logic eof,
                                            input logic last, input logic rej);
        framed_byte_t fb;
        fb.data = data;
        fb.eof  = eof;
        fb.last = last;
        fb.rej  = rej;
        return fb;
    endfunction

    // msb-first, top bit of the polynomial implied
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        repeat (8)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic encode_item(input logic [7:0] data, input logic sof, input logic [15:0] len);
        logic closes;
        if (sof)
        begin
            // a start always drops whatever frame was open
            bytes_left = '0;
            if (len == 16'd0 || len > max_len_cfg)
            begin
                framed_q.push_back(framed(8'h00, 1'b0, 1'b1, 1'b1));
                return;
            end
            framed_q.push_back(framed(SYNC_FIRST, 1'b0, 1'b0, 1'b0));
            framed_q.push_back(framed(SYNC_SECOND, 1'b0, 1'b0, 1'b0));
            framed_q.push_back(framed(len[7:0], 1'b0, 1'b0, 1'b0));
            framed_q.push_back(framed(len[15:8], 1'b0, 1'b0, 1'b0));
            crc_acc    = seed_cfg;
            bytes_left = len;
        end
        else if (bytes_left == 16'd0)
        begin
            return;
        end
        crc_acc    = crc8_next(crc_acc, data, poly_cfg);
        bytes_left = bytes_left - 16'd1;
        closes     = (bytes_left == 16'd0);
        framed_q.push_back(framed(data, 1'b0, !closes, 1'b0));
        if (closes)
        begin
            framed_q.push_back(framed(crc_acc, 1'b1, 1'b1, 1'b0));
        end
    endtask

    task automatic check_result();
        framed_byte_t want;
        if (framed_q.size() == 0)
        begin
            $error("result transfer with nothing expected: out_byte %02h", out_byte);
            mismatch_count++;
            return;
        end
        want = framed_q.pop_front();
        if (out_byte !== want.data)
        begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            mismatch_count++;
        end
        if (end_of_frame !== want.eof)
        begin
            $error("end_of_frame: expected %0b, actual %0b", want.eof, end_of_frame);
            mismatch_count++;
        end
        if (last_of_run !== want.last)
        begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
            mismatch_count++;
        end
        if (rejected !== want.rej)
        begin
            $error("rejected: expected %0b, actual %0b", want.rej, rejected);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_cfg = MAX_PAYLOAD_RESET;
            poly_cfg    = CRC_POLY_RESET;
            seed_cfg    = CRC_START_RESET;
            bytes_left  = '0;
            crc_acc     = '0;
            framed_q.delete();
            bytes_pending <= 0;
        end
        else
        begin
            // new item first, so a same-edge result still finds its entry
            if (item_valid && !item_stall)
            begin
                encode_item(payload_byte, start_of_frame, frame_length);
            end
            if (result_valid && !result_stall)
            begin
                check_result();
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_MAX_PAYLOAD: max_len_cfg = cfg_data[15:0];
                    REG_CRC_POLY:    poly_cfg    = cfg_data[7:0];
                    REG_CRC_START:   seed_cfg    = cfg_data[7:0];
                    default:         ;
                endcase
            end
            bytes_pending <= framed_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the frame encoder with directed corner cases and random frames under
// several register settings, with random gaps on both channels; the checker
// beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module testbench;
    import cfe_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int FRAME_CAP    = 12;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 25;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_write_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   item_valid     = 1'b0;
    logic                   item_stall;
    logic [7:0]             payload_byte   = '0;
    logic                   start_of_frame = 1'b0;
    logic [15:0]            frame_length   = '0;
    logic                   result_valid;
    logic                   result_stall   = 1'b0;
    logic [7:0]             out_byte;
    logic                   end_of_frame;
    logic                   last_of_run;
    logic                   rejected;

    int          mismatch_count;
    int          bytes_pending;
    int          counted     = 0;
    int          burst_left  = 0;
    logic [15:0] max_len_now = MAX_PAYLOAD_RESET;

    crc8_binary_frame_encoder_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .payload_byte   (payload_byte),
        .start_of_frame (start_of_frame),
        .frame_length   (frame_length),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .end_of_frame   (end_of_frame),
        .last_of_run    (last_of_run),
        .rejected       (rejected)
    );

    frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .payload_byte   (payload_byte),
        .start_of_frame (start_of_frame),
        .frame_length   (frame_length),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .end_of_frame   (end_of_frame),
        .last_of_run    (last_of_run),
        .rejected       (rejected),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    // output back-pressure, with occasional long free-flowing stretches
    initial
    begin
        int flowing;
        int held;
        forever
        begin
            flowing = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 6);
            held    = pick_gap();
            result_stall <= 1'b0;
            repeat (flowing) @(posedge clk);
            if (held > 0)
            begin
                result_stall <= 1'b1;
                repeat (held) @(posedge clk);
            end
        end
    end

    task automatic drive_item(input logic [7:0] data, input logic sof, input logic [15:0] len);
        int gap;
        item_valid     <= 1'b1;
        payload_byte   <= data;
        start_of_frame <= sof;
        frame_length   <= len;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // frame_length is ignored here, so it carries noise
    task automatic send_byte(input logic [7:0] data);
        drive_item(data, 1'b0, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_frame(input int len, input int sent);
        drive_item(8'($urandom_range(0, 255)), 1'b1, 16'(len));
        for (int i = 1; i < sent; i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        counted += sent;
    endtask

    // dropped bytes give no result, so let the block drain a little longer
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_PAYLOAD)
        begin
            max_len_now = val;
        end
    endtask

    initial
    begin
        int r;
        int len;
        int cap;
        int phase_target;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes outside a frame are dropped
        drive_item(8'h00, 1'b0, 16'hFFFF);
        drive_item(8'hFF, 1'b0, 16'h0000);
        // one-byte frame: header, data and crc from one transfer
        drive_item(8'hFF, 1'b1, 16'd1);
        drive_item(8'h5A, 1'b1, 16'd0);
        drive_item(8'h00, 1'b1, 16'd257);
        drive_item(8'hC3, 1'b1, 16'hFFFF);
        drive_item(8'h00, 1'b1, 16'd256);
        drive_item(8'h80, 1'b0, 16'h1234);
        drive_item(8'h01, 1'b0, 16'hEDCB);
        // restart aborts the open frame without a crc
        drive_item(8'h11, 1'b1, 16'd3);
        send_byte(8'h22);
        send_byte(8'h33);
        // a rejected start also closes an open frame
        drive_item(8'h44, 1'b1, 16'd5);
        send_byte(8'h55);
        drive_item(8'h66, 1'b1, 16'd0);
        send_byte(8'h77);

        wait_idle();
        write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
        write_reg(REG_CRC_POLY, {8'($urandom_range(0, 255)), 8'hFF});
        write_reg(REG_CRC_START, {8'($urandom_range(0, 255)), 8'hFF});
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        drive_item(8'hFF, 1'b1, 16'hFFFF);
        send_byte(8'h00);
        drive_item(8'hA5, 1'b1, 16'd2);
        send_byte(8'hFF);

        // zero maximum rejects every start
        wait_idle();
        write_reg(REG_MAX_PAYLOAD, 16'd0);
        drive_item(8'h12, 1'b1, 16'd1);

        wait_idle();
        write_reg(REG_MAX_PAYLOAD, 16'd1);
        write_reg(REG_CRC_POLY, 16'h0000);
        write_reg(REG_CRC_START, 16'h0000);
        drive_item(8'hFF, 1'b1, 16'd1);
        drive_item(8'hFF, 1'b1, 16'd2);

        // register change in the middle of an open frame
        wait_idle();
        write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
        write_reg(REG_CRC_POLY, {8'h00, CRC_POLY_RESET});
        write_reg(REG_CRC_START, 16'h005C);
        drive_item(8'h9E, 1'b1, 16'd4);
        send_byte(8'h01);
        wait_idle();
        write_reg(REG_CRC_POLY, 16'h0007);
        write_reg(REG_CRC_START, 16'h00EE);
        send_byte(8'hF0);
        send_byte(8'h0F);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            if (phase == 0)
            begin
                write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
                write_reg(REG_CRC_POLY, 16'h0000);
                write_reg(REG_CRC_START, 16'h0000);
            end
            else if (phase == 1)
            begin
                write_reg(REG_MAX_PAYLOAD, 16'd1);
                write_reg(REG_CRC_POLY, 16'h00FF);
                write_reg(REG_CRC_START, 16'h00FF);
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                begin
                    write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(1, 16)));
                end
                else if (r < 6)
                begin
                    write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(17, 300)));
                end
                else if (r < 8)
                begin
                    write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
                end
                else
                begin
                    write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
                end
                write_reg(REG_CRC_POLY, 16'($urandom_range(0, 65535)));
                write_reg(REG_CRC_START, 16'($urandom_range(0, 65535)));
            end

            phase_target = counted + PHASE_ITEMS;
            while (counted < phase_target)
            begin
                r   = $urandom_range(0, 99);
                cap = (max_len_now < FRAME_CAP) ? int'(max_len_now) : FRAME_CAP;
                if (r < 65)
                begin
                    len = $urandom_range(1, cap);
                    send_frame(len, len);
                end
                else if (r < 72)
                begin
                    len = $urandom_range(1, (max_len_now < 40) ? int'(max_len_now) : 40);
                    send_frame(len, len);
                end
                else if (r < 80)
                begin
                    // cut short when the cap allows; a later start aborts it unless stray bytes complete it
                    if (cap < 2)
                    begin
                        send_frame(1, 1);
                    end
                    else
                    begin
                        len = $urandom_range(2, cap);
                        send_frame(len, $urandom_range(1, len - 1));
                    end
                end
                else if (r < 88)
                begin
                    if (max_len_now == 16'hFFFF || $urandom_range(0, 1) == 0)
                    begin
                        len = 0;
                    end
                    else
                    begin
                        len = $urandom_range(int'(max_len_now) + 1, 65535);
                    end
                    drive_item(8'($urandom_range(0, 255)), 1'b1, 16'(len));
                    counted++;
                end
                else if (r < 95)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
                else if (r < 97)
                begin
                    wait_idle();
                end
                else
                begin
                    burst_left = $urandom_range(10, 40);
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0 && bytes_pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
